// File: rtl/ptf_pkg.sv
// shared types and helpers for the proth trial factor check block
// no dependencies
package ptf_pkg;

  localparam int unsigned WordW = 64;
  localparam int unsigned HalfW = 32;

  // request to the shared montgomery unit
  typedef struct packed {
    logic             start;
    logic [WordW-1:0] a;
    logic [WordW-1:0] b;
  } ptf_mm_req_t;

  // answer from the shared montgomery unit
  typedef struct packed {
    logic             done;
    logic [WordW-1:0] r;
  } ptf_mm_rsp_t;

  typedef enum logic [7:0] {
    StIdle  = 8'b0000_0001,
    StRinit = 8'b0000_0010,
    StSqIss = 8'b0000_0100,
    StSqWt  = 8'b0000_1000,
    StDbl   = 8'b0001_0000,
    StKmIss = 8'b0010_0000,
    StKmWt  = 8'b0100_0000,
    StFin   = 8'b1000_0000
  } ptf_state_e;

  // (2x) mod p for x < p
  function automatic logic [WordW-1:0] mod_dbl(input logic [WordW-1:0] x,
                                              input logic [WordW-1:0] p);
    logic [WordW:0] s;
    logic [WordW:0] d;
    s = {x, 1'b0};
    d = s - {1'b0, p};
    mod_dbl = (s >= {1'b0, p}) ? d[WordW-1:0] : s[WordW-1:0];
  endfunction

endpackage

// File: rtl/ptf_mont_mul.sv
// bit-serial montgomery multiplier, a*b/2^64 mod p, one bit of a per cycle
// depends on ptf_pkg
module ptf_mont_mul import ptf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ptf_mm_req_t      req_i,
  input  logic [WordW-1:0] p_i,
  output ptf_mm_rsp_t      rsp_o
);

  localparam int unsigned CntW = $clog2(WordW + 1);

  logic [WordW+1:0] t_q, t_d;
  logic [WordW-1:0] a_q, a_d, b_q, b_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic [WordW+1:0] s0, s1, sub;

  always_comb begin
    s0 = t_q + (a_q[0] ? {2'b00, b_q} : '0);
    s1 = s0 + (s0[0] ? {2'b00, p_i} : '0);
    sub = t_q - {2'b00, p_i};
  end

  always_comb begin
    t_d = t_q;
    a_d = a_q;
    b_d = b_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      t_d = '0;
      a_d = req_i.a;
      b_d = req_i.b;
      cnt_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (cnt_q == CntW'(WordW)) begin
        // final correction into [0, p)
        if (t_q >= {2'b00, p_i}) t_d = sub;
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        t_d = {1'b0, s1[WordW+1:1]};
        a_d = {1'b0, a_q[WordW-1:1]};
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q <= t_d;
    a_q <= a_d;
    b_q <= b_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.r = t_q[WordW-1:0];

endmodule

// File: rtl/proth_trial_factor_check_unit.sv
// top level of the proth trial factor check: sequencer and operand registers
// depends on ptf_pkg and ptf_mont_mul
//
//  channel   dir  payload                                    accepted when
//  s_axis    in   tdata: k[31:0] n[63:32] p[127:64]          tvalid & tready
//                 tuser: plus_one[0]
//  m_axis    out  tdata: divides[0], zeros above             tvalid & tready
//
// sequence: repeated modular doubling of one builds montgomery one, then 32
// squarings, each an issue state plus a wait on the shared bit-serial unit, one
// modular doubling per set exponent bit, a final multiply by k on the same unit
// and one finish state before the result is valid; the sequencer then returns
// to idle, and only there can the next item be taken.
// an even modulus or one below three goes from accept straight to the finish state with divides = 0.
// reset clears the sequencer and the output valid; payload registers keep junk.
// s_axis_tready is high only when idle; a result waits in its register while
// the next item is taken, and only the finish of that next item stalls on it.
module proth_trial_factor_check_unit import ptf_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,  // multiplier, exponent, modulus
  input  logic [0:0]   s_axis_tuser,  // plus_one
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [7:0]   m_axis_tdata   // divides, zero fill
);

  ptf_state_e       state_q, state_d;
  logic [HalfW-1:0] k_q, k_d, n_q, n_d;
  logic [WordW-1:0] p_q, p_d, a_q, a_d;
  logic             plus_q, plus_d;
  logic [5:0]       cnt_q, cnt_d;     // montgomery one doubling count
  logic [4:0]       bit_q, bit_d;     // exponent bit under scan
  logic             res_q, res_d;
  logic             ov_q, ov_d, od_q, od_d;
  ptf_mm_req_t      req;
  ptf_mm_rsp_t      rsp;
  logic [WordW-1:0] in_p;

  assign in_p = s_axis_tdata[127:64];
  assign s_axis_tready = (state_q == StIdle);

  ptf_mont_mul u_mm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .p_i    (p_q),
    .rsp_o  (rsp)
  );

  always_comb begin
    state_d = state_q;
    k_d = k_q;
    n_d = n_q;
    p_d = p_q;
    plus_d = plus_q;
    a_d = a_q;
    cnt_d = cnt_q;
    bit_d = bit_q;
    res_d = res_q;
    ov_d = ov_q;
    od_d = od_q;
    req.start = 1'b0;
    req.a = a_q;
    req.b = a_q;
    if (m_axis_tvalid && m_axis_tready) ov_d = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (s_axis_tvalid) begin
          k_d = s_axis_tdata[31:0];
          n_d = s_axis_tdata[63:32];
          p_d = in_p;
          plus_d = s_axis_tuser[0];
          a_d = WordW'(1);
          cnt_d = '0;
          bit_d = 5'd31;
          res_d = 1'b0;
          // montgomery form needs an odd modulus of at least three
          if (!in_p[0] || in_p < WordW'(3)) state_d = StFin;
          else state_d = StRinit;
        end
      end
      StRinit: begin
        // 2^64 mod p by repeated modular doubling of one
        a_d = mod_dbl(a_q, p_q);
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 6'd63) state_d = StSqIss;
      end
      StSqIss: begin
        req.start = 1'b1;
        state_d = StSqWt;
      end
      StSqWt: begin
        if (rsp.done) begin
          a_d = rsp.r;
          if (n_q[bit_q]) state_d = StDbl;
          else if (bit_q == '0) state_d = StKmIss;
          else begin
            bit_d = bit_q - 1'b1;
            state_d = StSqIss;
          end
        end
      end
      StDbl: begin
        a_d = mod_dbl(a_q, p_q);
        if (bit_q == '0) state_d = StKmIss;
        else begin
          bit_d = bit_q - 1'b1;
          state_d = StSqIss;
        end
      end
      StKmIss: begin
        // multiply by k leaves montgomery form
        req.start = 1'b1;
        req.b = {{(WordW-HalfW){1'b0}}, k_q};
        state_d = StKmWt;
      end
      StKmWt: begin
        if (rsp.done) begin
          res_d = plus_q ? (rsp.r == p_q - WordW'(1)) : (rsp.r == WordW'(1));
          state_d = StFin;
        end
      end
      StFin: begin
        // wait for the output slot to be free
        if (!ov_q || m_axis_tready) begin
          ov_d = 1'b1;
          od_d = res_q;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q <= k_d;
    n_q <= n_d;
    p_q <= p_d;
    plus_q <= plus_d;
    a_q <= a_d;
    cnt_q <= cnt_d;
    bit_q <= bit_d;
    res_q <= res_d;
    od_q <= od_d;
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata = {7'b0, od_q};

endmodule
